@@ hdl/length_prefixed_message_ring_top_defines.svh @@
// Assertion macros for the length-prefixed message ring.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_TOP_DEFINES_SVH
// Checks that a condition implies another in the same cycle.
`define LPMR_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Checks that a condition implies another in the next cycle.
`define LPMR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

@@ hdl/lpmr_pkg.sv @@
// Package with shared types and codes of the message ring.
package lpmr_pkg;
  localparam int unsigned PrefixBytes = 4;
  localparam int unsigned RingDepth = 4096;

  typedef enum logic [1:0] {
    OP_SEND_BEGIN = 2'd0,
    OP_SEND_BYTE  = 2'd1,
    OP_RECV_BEGIN = 2'd2,
    OP_RECV_BYTE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOTHING   = 3'd2,
    ST_ZERO      = 3'd3,
    ST_CORRUPT   = 3'd4,
    ST_TOO_LARGE = 3'd5,
    ST_SEQ       = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] msg_len;
    logic [7:0]  data_in;
    logic [12:0] max_len;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic [12:0] msg_size;
    logic        last_byte;
    logic [11:0] bytes_ready;
    logic [11:0] free_space;
  } rsp_t;
endpackage

@@ hdl/lpmr_req_if.sv @@
// Valid/ready channel interface carrying requests.
interface lpmr_req_if import lpmr_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/lpmr_rsp_if.sv @@
// Valid/ready channel interface carrying results.
interface lpmr_rsp_if import lpmr_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/lpmr_cfg_if.sv @@
// Valid/ready configuration write channel.
interface lpmr_cfg_if ();
  logic        valid;
  logic        ready;
  logic [12:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/lpmr_front.sv @@
// Front stage: registers incoming requests into a two-entry queue.
module lpmr_front import lpmr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lpmr_req_if.sink in_req,
  output logic q_valid_o,
  output req_t q_data_o,
  input  logic q_pop_i,
  input  logic flush_i
);
  req_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_req.ready = (cnt_q != 2'd2) && !flush_i;
  assign push = in_req.valid && in_req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_req.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (q_pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

@@ hdl/lpmr_back.sv @@
// Back stage: ring memory, pointers and the per-request sequencer.
module lpmr_back import lpmr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  req_t        q_data_i,
  output logic        q_pop_o,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_data_i,
  lpmr_rsp_if.source  out_rsp
);
  typedef enum logic [2:0] {
    S_IDLE, S_WPFX, S_WPAD, S_RPFX, S_RWAIT, S_DECIDE, S_RBYTE, S_OUT
  } state_e;

  state_e      state_q;
  logic [7:0]  mem [RingDepth];
  logic [7:0]  rdata_q;
  logic [12:0] len_q;
  logic [12:0] eff;
  logic [11:0] head_q, tail_q, wcur_q, rcur_q, ptail_q;
  logic [12:0] wleft_q, rleft_q;
  logic [1:0]  pad_q, idx_q;
  logic        sending_q, receiving_q;
  logic [31:0] size_q;
  logic [12:0] padded_q;
  req_t        req_q;
  rsp_t        rsp_q;
  logic        we;
  logic [11:0] waddr, raddr;
  logic [7:0]  wdata;
  logic [12:0] ready_c;

  // Effective ring length, clamped to the legal range.
  always_comb begin
    if (len_q < 13'd8) eff = 13'd8;
    else if (len_q > 13'(RingDepth)) eff = 13'(RingDepth);
    else eff = len_q;
  end

  function automatic logic [11:0] wadd(input logic [11:0] p, input logic [13:0] n,
                                       input logic [12:0] l);
    logic [14:0] s;
    s = {3'd0, p} + {1'b0, n};
    if (s >= {2'd0, l}) s = s - {2'd0, l};
    if (s >= {2'd0, l}) s = s - {2'd0, l};
    return s[11:0];
  endfunction

  always_comb begin
    if (head_q >= tail_q) ready_c = {1'b0, head_q - tail_q};
    else ready_c = eff - {1'b0, tail_q} + {1'b0, head_q};
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Pointers do not move while a result waits, so the fill levels follow them directly.
  assign out_rsp.valid = (state_q == S_OUT);
  always_comb begin
    out_rsp.data = rsp_q;
    out_rsp.data.bytes_ready = ready_c[11:0];
    out_rsp.data.free_space = 12'(eff - 13'd1 - ready_c);
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    waddr = wcur_q;
    wdata = 8'd0;
    raddr = rcur_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE: q_pop_o = q_valid_i;
      S_WPFX: begin
        we = 1'b1;
        waddr = wadd(head_q, {12'd0, idx_q}, eff);
        if (idx_q == 2'd0) wdata = padded_q[7:0];
        else if (idx_q == 2'd1) wdata = {3'd0, padded_q[12:8]};
      end
      S_WPAD: we = (pad_q != 2'd0);
      S_RPFX: raddr = wadd(tail_q, {12'd0, idx_q}, eff);
      default: ;
    endcase
    if (state_q == S_IDLE && q_valid_i && q_data_i.op == OP_SEND_BYTE && sending_q) begin
      we = 1'b1;
      wdata = q_data_i.data_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [12:0] padded, space;
    logic [12:0] pz;
    logic [13:0] need;
    rsp_t        nr;
    state_e      nxt;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= 13'd4096;
      head_q <= '0; tail_q <= '0; wcur_q <= '0; rcur_q <= '0; ptail_q <= '0;
      wleft_q <= '0; rleft_q <= '0; pad_q <= '0; idx_q <= '0;
      sending_q <= 1'b0; receiving_q <= 1'b0;
      size_q <= '0; padded_q <= '0; req_q <= '0; rsp_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_data_i;
      head_q <= '0; tail_q <= '0; wcur_q <= '0; rcur_q <= '0; ptail_q <= '0;
      wleft_q <= '0; rleft_q <= '0; pad_q <= '0;
      sending_q <= 1'b0; receiving_q <= 1'b0;
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (q_valid_i) begin
          req_q <= q_data_i;
          nr = '0;
          nr.status = ST_OK;
          nxt = S_OUT;
          unique case (op_e'(q_data_i.op))
            OP_SEND_BEGIN: begin
              padded = ({1'b0, q_data_i.msg_len} + 13'd3) & ~13'd3;
              space = eff - 13'd1 - ready_c;
              if (sending_q) nr.status = ST_SEQ;
              else if ({1'b0, space} < {1'b0, padded} + 14'd4) nr.status = ST_NO_SPACE;
              else begin
                padded_q <= padded;
                idx_q <= 2'd0;
                wleft_q <= {1'b0, q_data_i.msg_len};
                pad_q <= 2'(padded - {1'b0, q_data_i.msg_len});
                nxt = S_WPFX;
              end
            end
            OP_SEND_BYTE: begin
              if (!sending_q) nr.status = ST_SEQ;
              else begin
                wcur_q <= wadd(wcur_q, 14'd1, eff);
                wleft_q <= wleft_q - 13'd1;
                if (wleft_q == 13'd1) nxt = S_WPAD;
              end
            end
            OP_RECV_BEGIN: begin
              if (receiving_q) nr.status = ST_SEQ;
              else if (ready_c < 13'd4) nr.status = ST_NOTHING;
              else begin
                idx_q <= 2'd0;
                nxt = S_RPFX;
              end
            end
            default: begin
              if (!receiving_q) nr.status = ST_SEQ;
              else begin
                rcur_q <= wadd(rcur_q, 14'd1, eff);
                rleft_q <= rleft_q - 13'd1;
                nxt = S_RBYTE;
              end
            end
          endcase
          rsp_q <= nr;
          state_q <= nxt;
        end
        S_WPFX: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            wcur_q <= wadd(head_q, 14'd4, eff);
            if (wleft_q == 13'd0) begin
              head_q <= wadd(head_q, 14'd4, eff);
              state_q <= S_OUT;
            end else begin
              sending_q <= 1'b1;
              state_q <= S_OUT;
            end
          end
        end
        S_WPAD: begin
          if (pad_q != 2'd0) begin
            pad_q <= pad_q - 2'd1;
            wcur_q <= wadd(wcur_q, 14'd1, eff);
          end else begin
            head_q <= wcur_q;
            sending_q <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_RPFX: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q != 2'd0) size_q[8*(idx_q-2'd1) +: 8] <= rdata_q;
          if (idx_q == 2'd3) state_q <= S_RWAIT;
        end
        S_RWAIT: begin
          size_q[31:24] <= rdata_q;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          pz = size_q[12:0];
          need = {1'b0, pz} + 14'd4;
          state_q <= S_OUT;
          if (size_q == 32'd0) begin
            tail_q <= wadd(tail_q, 14'd4, eff);
            rsp_q.status <= ST_ZERO;
          end else if (size_q > {19'd0, eff}) begin
            tail_q <= head_q;
            rsp_q.status <= ST_CORRUPT;
          end else if ({1'b0, ready_c} < need) begin
            rsp_q.status <= ST_NOTHING;
          end else if (pz > req_q.max_len) begin
            tail_q <= wadd(tail_q, need, eff);
            rsp_q.status <= ST_TOO_LARGE;
          end else begin
            rcur_q <= wadd(tail_q, 14'd4, eff);
            rleft_q <= pz;
            ptail_q <= wadd(tail_q, need, eff);
            receiving_q <= 1'b1;
            rsp_q.msg_size <= pz;
          end
        end
        S_RBYTE: begin
          rsp_q.data_out <= rdata_q;
          if (rleft_q == 13'd0) begin
            rsp_q.last_byte <= 1'b1;
            tail_q <= ptail_q;
            receiving_q <= 1'b0;
          end
          state_q <= S_OUT;
        end
        default: begin
          if (out_rsp.ready) state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule

@@ hdl/length_prefixed_message_ring_top.sv @@
// The back stage handles one request at a time through the byte-wide ring memory: an
// accepted send_begin writes the four prefix bytes, the last send_byte writes the padding
// bytes, and a receive_begin reads the prefix before it decides. The front queue holds up
// to two waiting requests; the next is taken only after the current result is accepted.
// Reset clears pointers and sets ring length to 4096; ring contents are not cleared.
// A configuration write empties the ring and drops open sends and receives.
module length_prefixed_message_ring_top import lpmr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  lpmr_req_if.sink   in_req,
  lpmr_rsp_if.source out_rsp,
  lpmr_cfg_if.sink   cfg
);
`include "length_prefixed_message_ring_top_defines.svh"
  logic q_valid, q_pop;
  req_t q_data;
  logic cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we = cfg.valid;

  lpmr_front u_front (
    .clk_i, .rst_ni, .in_req,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop), .flush_i(1'b0)
  );

  lpmr_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg.data), .out_rsp
  );

  `LPMR_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_rsp.valid,
    out_rsp.data.status <= ST_SEQ, "status code out of range")
  `LPMR_ASSERT_IMP(a_last_only_ok, clk_i, rst_ni, out_rsp.valid && out_rsp.data.last_byte,
    out_rsp.data.status == ST_OK, "last_byte with non-ok status")
  `LPMR_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_rsp.valid && !out_rsp.ready && !cfg.valid,
    out_rsp.valid && $stable(out_rsp.data), "result changed while stalled")
endmodule

@@ tb/length_prefixed_message_ring_top_test.sv @@
// Self-checking testbench for the length-prefixed message ring top level.
module length_prefixed_message_ring_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lpmr_pkg::*;

  localparam int unsigned Depth = 4096;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk;
  logic rst_n;

  lpmr_req_if req_ch ();
  lpmr_rsp_if rsp_ch ();
  lpmr_cfg_if cfg_ch ();

  length_prefixed_message_ring_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch),
    .cfg    (cfg_ch)
  );

  // Shadow copy of the ring state.
  logic [7:0]  ring_mem [Depth];
  int unsigned ring_len_reg;
  int unsigned head_ptr, tail_ptr, wr_pos, wr_left, wr_pad;
  bit          in_send;
  int unsigned rd_pos, rd_left, rd_end;
  bit          in_recv;

  rsp_t        expected_rsp_q[$];
  row_t        directed_rows[$];
  int          error_count = 0;
  int          rsp_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned span();
    if (ring_len_reg < 8) return 8;
    if (ring_len_reg > Depth) return Depth;
    return ring_len_reg;
  endfunction

  function automatic int unsigned ready_count();
    int unsigned h, t, n;
    n = span();
    h = head_ptr % n;
    t = tail_ptr % n;
    return (h >= t) ? h - t : n - t + h;
  endfunction

  function automatic void clear_ring_state();
    head_ptr = 0; tail_ptr = 0; wr_pos = 0; wr_left = 0; wr_pad = 0; in_send = 0;
    rd_pos = 0; rd_left = 0; rd_end = 0; in_recv = 0;
  endfunction

  // Advances the shadow state by one request and returns the result it causes.
  function automatic rsp_t ring_step(req_t r);
    rsp_t        o;
    int unsigned n, padded, size, avail;
    n = span();
    o = '0;
    o.status = ST_OK;
    case (op_e'(r.op))
      OP_SEND_BEGIN: begin
        padded = (r.msg_len + 3) & ~32'd3;
        if (in_send) begin
          o.status = ST_SEQ;
        end else if (n - 1 - ready_count() < PrefixBytes + padded) begin
          o.status = ST_NO_SPACE;
        end else begin
          for (int i = 0; i < PrefixBytes; i++)
            ring_mem[(head_ptr + i) % n] = 8'(padded >> (8 * i));
          wr_pos = (head_ptr + PrefixBytes) % n;
          wr_left = r.msg_len;
          wr_pad = padded - r.msg_len;
          if (r.msg_len == 0) head_ptr = wr_pos;
          else in_send = 1;
        end
      end
      OP_SEND_BYTE: begin
        if (!in_send) begin
          o.status = ST_SEQ;
        end else begin
          ring_mem[wr_pos] = r.data_in;
          wr_pos = (wr_pos + 1) % n;
          wr_left--;
          if (wr_left == 0) begin
            for (int i = 0; i < wr_pad; i++) begin
              ring_mem[wr_pos] = 8'h00;
              wr_pos = (wr_pos + 1) % n;
            end
            wr_pad = 0;
            head_ptr = wr_pos;
            in_send = 0;
          end
        end
      end
      OP_RECV_BEGIN: begin
        avail = ready_count();
        if (in_recv) begin
          o.status = ST_SEQ;
        end else if (avail < PrefixBytes) begin
          o.status = ST_NOTHING;
        end else begin
          size = 0;
          for (int i = 0; i < PrefixBytes; i++)
            size |= int'(ring_mem[(tail_ptr + i) % n]) << (8 * i);
          if (size == 0) begin
            tail_ptr = (tail_ptr + PrefixBytes) % n;
            o.status = ST_ZERO;
          end else if (size > n) begin
            tail_ptr = head_ptr;
            o.status = ST_CORRUPT;
          end else if (avail < PrefixBytes + size) begin
            o.status = ST_NOTHING;
          end else if (size > r.max_len) begin
            tail_ptr = (tail_ptr + PrefixBytes + size) % n;
            o.status = ST_TOO_LARGE;
          end else begin
            rd_pos = (tail_ptr + PrefixBytes) % n;
            rd_left = size;
            rd_end = (tail_ptr + PrefixBytes + size) % n;
            in_recv = 1;
            o.msg_size = 13'(size);
          end
        end
      end
      default: begin
        if (!in_recv) begin
          o.status = ST_SEQ;
        end else begin
          o.data_out = ring_mem[rd_pos];
          rd_pos = (rd_pos + 1) % n;
          rd_left--;
          if (rd_left == 0) begin
            o.last_byte = 1'b1;
            tail_ptr = rd_end;
            in_recv = 0;
          end
        end
      end
    endcase
    o.bytes_ready = 12'(ready_count());
    o.free_space = 12'(n - 1 - ready_count());
    return o;
  endfunction

  function automatic void add_row(op_e op, int unsigned len, int unsigned data,
                                  int unsigned maxl, bit typed, status_e st,
                                  int unsigned rdy);
    row_t w;
    w.req = '{op: op, msg_len: 12'(len), data_in: 8'(data), max_len: 13'(maxl)};
    w.typed = typed;
    w.want = '0;
    w.want.status = st;
    w.want.bytes_ready = 12'(rdy);
    w.want.free_space = 12'(4095 - rdy);
    directed_rows.push_back(w);
  endfunction

  task automatic put_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic write_ring_length(logic [12:0] v);
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    ring_len_reg = v;
    clear_ring_state();
  endtask

  function automatic req_t pick_request();
    req_t        r;
    int unsigned n;
    n = span();
    r.msg_len = 12'($urandom);
    r.data_in = 8'($urandom);
    r.max_len = ($urandom_range(99) < 80) ? 13'h1FFF : 13'($urandom_range(0, 64));
    if ($urandom_range(99) < 10) begin
      r.op = 2'($urandom);
      return r;
    end
    if (in_send) r.op = OP_SEND_BYTE;
    else if (in_recv) r.op = OP_RECV_BYTE;
    else if ($urandom_range(99) < ((ready_count() < n / 2) ? 65 : 35)) r.op = OP_SEND_BEGIN;
    else r.op = OP_RECV_BEGIN;
    if (r.op == OP_SEND_BEGIN) begin
      case ($urandom_range(9))
        0: ;
        1, 2: r.msg_len = 12'($urandom_range(0, n));
        default: r.msg_len = 12'($urandom_range(0, 24));
      endcase
    end
    return r;
  endfunction

  // Result side: random stalls and comparison with the oldest expectation.
  initial begin
    rsp_t e, a;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        a = rsp_ch.data;
        rsp_count++;
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          e = expected_rsp_q.pop_front();
          if (a.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, a.status); error_count++;
          end
          if (a.data_out !== e.data_out) begin
            $error("data_out expected %0d got %0d", e.data_out, a.data_out); error_count++;
          end
          if (a.msg_size !== e.msg_size) begin
            $error("msg_size expected %0d got %0d", e.msg_size, a.msg_size); error_count++;
          end
          if (a.last_byte !== e.last_byte) begin
            $error("last_byte expected %0d got %0d", e.last_byte, a.last_byte);
            error_count++;
          end
          if (a.bytes_ready !== e.bytes_ready) begin
            $error("bytes_ready expected %0d got %0d", e.bytes_ready, a.bytes_ready);
            error_count++;
          end
          if (a.free_space !== e.free_space) begin
            $error("free_space expected %0d got %0d", e.free_space, a.free_space);
            error_count++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [12:0] ring_lengths[7] = '{13'd64, 13'd8, 13'd5, 13'd8191, 13'd37, 13'd4096,
                                     13'd200};
    int unsigned idle_mode[4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{9, 9}};
    req_t r;
    rsp_t e;
    int   wait_cycles;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    for (int i = 0; i < Depth; i++) ring_mem[i] = 8'h00;
    ring_len_reg = 4096;
    clear_ring_state();
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring, out-of-order requests, size limit, empty message, padding.
    add_row(OP_RECV_BEGIN, 0, 0, 4096, 1, ST_NOTHING, 0);
    add_row(OP_RECV_BYTE, 0, 0, 0, 1, ST_SEQ, 0);
    add_row(OP_SEND_BYTE, 0, 8'hFF, 0, 1, ST_SEQ, 0);
    add_row(OP_SEND_BEGIN, 4095, 0, 0, 1, ST_NO_SPACE, 0);
    add_row(OP_SEND_BEGIN, 0, 0, 0, 1, ST_OK, 4);
    add_row(OP_RECV_BEGIN, 0, 0, 0, 1, ST_ZERO, 0);
    add_row(OP_SEND_BEGIN, 5, 0, 0, 0, ST_OK, 0);
    add_row(OP_SEND_BEGIN, 3, 0, 0, 1, ST_SEQ, 0);
    add_row(OP_SEND_BYTE, 0, 8'hFF, 0, 0, ST_OK, 0);
    add_row(OP_SEND_BYTE, 0, 8'h00, 0, 0, ST_OK, 0);
    add_row(OP_SEND_BYTE, 0, 8'hAA, 0, 0, ST_OK, 0);
    add_row(OP_SEND_BYTE, 0, 8'h55, 0, 0, ST_OK, 0);
    add_row(OP_SEND_BYTE, 0, 8'h80, 0, 0, ST_OK, 0);
    add_row(OP_RECV_BEGIN, 0, 0, 4, 1, ST_TOO_LARGE, 0);
    add_row(OP_SEND_BEGIN, 3, 0, 0, 0, ST_OK, 0);
    add_row(OP_SEND_BYTE, 0, 8'h01, 0, 0, ST_OK, 0);
    add_row(OP_SEND_BYTE, 0, 8'hFE, 0, 0, ST_OK, 0);
    add_row(OP_SEND_BYTE, 0, 8'h7F, 0, 0, ST_OK, 0);
    add_row(OP_RECV_BEGIN, 4095, 8'hFF, 8191, 0, ST_OK, 0);
    add_row(OP_RECV_BEGIN, 0, 0, 8191, 1, ST_SEQ, 8);
    for (int i = 0; i < 4; i++) add_row(OP_RECV_BYTE, 0, 0, 0, 0, ST_OK, 0);

    foreach (directed_rows[i]) begin
      e = ring_step(directed_rows[i].req);
      expected_rsp_q.push_back(directed_rows[i].typed ? directed_rows[i].want : e);
      put_request(directed_rows[i].req);
    end

    foreach (ring_lengths[p]) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_ring_length(ring_lengths[p]);
      send_idle_pct = idle_mode[p % 4][0];
      recv_stall_pct = idle_mode[p % 4][1];
      for (int k = 0; k < 112; k++) begin
        // Let the block drain completely once per phase.
        if (k == 50) begin
          req_ch.valid <= 1'b0;
          while (expected_rsp_q.size() != 0) @(posedge clk);
        end
        r = pick_request();
        expected_rsp_q.push_back(ring_step(r));
        put_request(r);
      end
    end
    req_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (expected_rsp_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    error_count += expected_rsp_q.size();
    $display("Covered %0d directed and %0d random requests over %0d ring lengths,",
             directed_rows.size(), 112 * 7, 7);
    $display("with sender gaps and receiver stalls; %0d results checked.", rsp_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
